/* src/bbs_pkg.sv */
// Shared types and constants for the bounded bag store.
package bbs_pkg;

    localparam int KEY_W     = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 5;
    localparam int CAP_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_DEL   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    typedef struct packed {
        logic                 valid;
        status_t              status;
        logic                 found;
        logic [CNT_OUT_W-1:0] count;
        logic                 is_full;
        logic                 is_empty;
    } res_t;

endpackage

/* src/bbs_mem.sv */
// Key storage: one write port and one read port with registered read data.
module bbs_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [bbs_pkg::KEY_W-1:0] wdata,
    input  logic [AW-1:0]             raddr,
    output logic [bbs_pkg::KEY_W-1:0] rdata
);
    import bbs_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* src/bbs_ctrl.sv */
// Command sequencer: fill count, entry scan and swap-with-last removal.
module bbs_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             ready,
    input  logic [bbs_pkg::CMD_W-1:0]        cmd,
    input  logic signed [bbs_pkg::KEY_W-1:0] key,
    input  logic [bbs_pkg::CAP_W-1:0]        capacity,
    input  logic                             res_ready,
    output bbs_pkg::res_t                    res,
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output logic [bbs_pkg::KEY_W-1:0]        mem_wdata,
    output logic [AW-1:0]                    mem_raddr,
    input  logic [bbs_pkg::KEY_W-1:0]        mem_rdata
);
    import bbs_pkg::*;

    localparam int CMPW = ((CW > CAP_W) ? CW : CAP_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_MOVE = 4'b0100,
        S_RESP = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    cmd_t              cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     pos_reg, pos_next;
    status_t           status_reg, status_next;
    logic              found_reg, found_next;

    logic [CMPW-1:0]   cap_ext;
    logic [CMPW-1:0]   eff_cap;
    logic [CW-1:0]     cnt_m1;
    logic              is_full;
    logic              hit;
    logic              last;

    // Capacity is clamped to 1..DEPTH before it is compared with the count.
    always_comb
    begin
        cap_ext = CMPW'(capacity);
        if (cap_ext == '0)
        begin
            eff_cap = CMPW'(1);
        end
        else if (cap_ext > CMPW'(DEPTH))
        begin
            eff_cap = CMPW'(DEPTH);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign is_full = CMPW'(cnt_reg) >= eff_cap;
    assign cnt_m1  = cnt_reg - CW'(1);
    assign hit     = mem_rdata == key_reg;
    assign last    = CW'(idx_reg) == cnt_m1;
    assign ready   = state_reg == S_IDLE;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd_next    = cmd_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = key_reg;
        mem_raddr   = '0;

        res          = '0;
        res.status   = status_reg;
        res.found    = found_reg;
        res.count    = CNT_OUT_W'(cnt_reg);
        res.is_full  = is_full;
        res.is_empty = cnt_reg == '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd_t'(cmd);
                    key_next    = key;
                    found_next  = 1'b0;
                    status_next = ST_DONE;
                    state_next  = S_RESP;
                    case (cmd_t'(cmd))
                        CMD_ADD:
                        begin
                            if (is_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cnt_reg[AW-1:0];
                                mem_wdata = key;
                                cnt_next  = cnt_reg + CW'(1);
                            end
                        end
                        CMD_DEL, CMD_QUERY:
                        begin
                            if (cnt_reg == '0)
                            begin
                                if (cmd_t'(cmd) == CMD_DEL)
                                begin
                                    status_next = ST_NOT_FOUND;
                                end
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Read data belongs to idx_reg; the next address is issued in
                // the same cycle so the scan runs one entry per cycle.
                if (hit)
                begin
                    found_next = 1'b1;
                    if (cmd_reg == CMD_DEL)
                    begin
                        mem_raddr  = cnt_m1[AW-1:0];
                        pos_next   = idx_reg;
                        state_next = S_MOVE;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (last)
                begin
                    if (cmd_reg == CMD_DEL)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    state_next = S_RESP;
                end
                else
                begin
                    mem_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
            end
            S_MOVE:
            begin
                // The last stored key fills the slot of the removed one.
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = mem_rdata;
                cnt_next   = cnt_m1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        found_reg  <= found_next;
    end

endmodule

/* src/bounded_bag_store_core.sv */
// Top level of the bounded bag store: channels, capacity register, result register.
//
// Usage: a request on the s_ channel carries a key in s_tdata and a command in
// s_tuser (add, delete first match, query). Every request yields exactly one
// result on the m_ channel: status in m_tuser, and found, count, full and
// empty flags in m_tdata. Requests are handled one at a time.
// Add, the unused command and a query or delete on an empty bag go straight
// to the result; a query or delete otherwise scans the stored entries (at
// most DEPTH) first. The scan reads the key memory one entry per cycle
// through its single read port; a matched delete then reads the last entry
// and writes it over the matching slot.
// The capacity register is written through cfg_valid/cfg_data; the user must
// write it only while the block is idle, which the block itself does not
// enforce. cfg_ready is always high. Reset empties the bag (count zero) and
// sets capacity to 16; the key memory is not cleared since only filled
// entries are read. When the receiver stalls, the result waits in the output
// register and the next request is taken, but its result is held back until
// the output register frees.
module bounded_bag_store_core #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [31:0]                   s_tdata,   // key_value[31:0]
    input  logic [1:0]                    s_tuser,   // cmd[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // is_empty, is_full, count[4:0], found
    output logic [1:0]                    m_tuser,   // status[1:0]
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bbs_pkg::CAP_W-1:0]     cfg_data
);
    import bbs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CAP_W-1:0] cap_reg;
    logic             m_tvalid_reg;
    logic [7:0]       m_tdata_reg;
    logic [1:0]       m_tuser_reg;
    logic             out_free;
    res_t             res;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [KEY_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [KEY_W-1:0] mem_rdata;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    bbs_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (s_tvalid && s_tready),
        .ready     (s_tready),
        .cmd       (s_tuser),
        .key       ($signed(s_tdata)),
        .capacity  (cap_reg),
        .res_ready (out_free),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    bbs_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (res.valid && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && out_free)
        begin
            m_tdata_reg <= {res.is_empty, res.is_full, res.count, res.found};
            m_tuser_reg <= res.status;
        end
    end

endmodule
